// File: rtl/nmmc6_pkg.sv
// ----------------------------------------------------------------------------
// nmmc6_pkg: shared types and constants of the MMC6 bank mapper.
// Holds the item modes, register decode codes, bank targets and the
// mapper state bundle passed from the register file to the translator.
// ----------------------------------------------------------------------------
package nmmc6_pkg;

    // Item modes.
    typedef enum logic [1:0] {
        MODE_WRITE     = 2'd0,
        MODE_TICK      = 2'd1,
        MODE_CPU_XLATE = 2'd2,
        MODE_PPU_XLATE = 2'd3
    } t_mode;

    // Register decode: {addr[15:13], addr[0]}, the bits kept by AND 0xE001.
    typedef enum logic [3:0] {
        REG_SELECT    = 4'b1000,
        REG_BANK_DATA = 4'b1001,
        REG_MIRROR    = 4'b1010,
        REG_SRAM_CTRL = 4'b1011,
        REG_IRQ_LATCH = 4'b1100,
        REG_IRQ_RELD  = 4'b1101,
        REG_IRQ_OFF   = 4'b1110,
        REG_IRQ_ON    = 4'b1111
    } t_reg_sel;

    // Bank data targets, held in bank_select bits 2:0.
    typedef enum logic [2:0] {
        TGT_CHR_PAIR0 = 3'd0,
        TGT_CHR_PAIR1 = 3'd1,
        TGT_CHR4      = 3'd2,
        TGT_CHR5      = 3'd3,
        TGT_CHR6      = 3'd4,
        TGT_CHR7      = 3'd5,
        TGT_PRG0      = 3'd6,
        TGT_PRG1      = 3'd7
    } t_bank_tgt;

    localparam int unsigned PRG_BANKS  = 2;
    localparam int unsigned CHR_BANKS  = 8;
    localparam int unsigned PRG_W      = 6;
    localparam int unsigned CHR_W      = 8;

    localparam logic [7:0] SELECT_MASK   = 8'hC7;
    localparam int unsigned SEL_PRG_SWAP = 6;
    localparam int unsigned SEL_CHR_INV  = 7;
    localparam int unsigned SEL_SRAM_EN  = 5;

    localparam logic [7:0] PRG_FIXED_2ND  = 8'h3E;
    localparam logic [7:0] PRG_FIXED_LAST = 8'h3F;

    localparam logic [8:0] LINE_FIRST = 9'd20;
    localparam logic [8:0] LINE_LAST  = 9'd260;

    // Mapper state seen by the address translator.
    typedef struct packed {
        logic [7:0]                          bank_select;
        logic [PRG_BANKS-1:0][PRG_W-1:0]     prg_banks;
        logic [CHR_BANKS-1:0][CHR_W-1:0]     chr_banks;
    } t_map_state;

endpackage

// File: rtl/nmmc6_regs.sv
// ----------------------------------------------------------------------------
// nmmc6_regs: mapper register file and scanline IRQ counter.
// Decodes CPU register writes, clocks the IRQ counter on scanline ticks and
// presents the bank state and the post-item mirror and SRAM flags.
// ----------------------------------------------------------------------------
module nmmc6_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [1:0]            i_mode,
    input  logic [15:0]           i_addr,
    input  logic [7:0]            i_data,
    input  logic [8:0]            i_line,
    input  logic [1:0]            i_render_bits,
    output nmmc6_pkg::t_map_state o_map,
    output logic                  o_irq_pulse,
    output logic                  o_mirror,
    output logic                  o_sram_mapped
);

    logic [7:0] r_bank_select, n_bank_select;
    logic [nmmc6_pkg::PRG_BANKS-1:0][nmmc6_pkg::PRG_W-1:0] r_prg, n_prg;
    logic [nmmc6_pkg::CHR_BANKS-1:0][nmmc6_pkg::CHR_W-1:0] r_chr, n_chr;
    logic       r_mirror, n_mirror;
    logic       r_sram_en, n_sram_en;
    logic [7:0] r_sram_ctrl, n_sram_ctrl;
    logic [7:0] r_irq_latch, n_irq_latch;
    logic [7:0] r_irq_count, n_irq_count;
    logic       r_irq_en, n_irq_en;
    logic       r_irq_reload, n_irq_reload;

    logic       is_write;
    logic       is_tick;
    logic       tick_live;
    logic [7:0] data_even;

    assign is_write  = i_en && (i_mode == nmmc6_pkg::MODE_WRITE);
    assign is_tick   = i_en && (i_mode == nmmc6_pkg::MODE_TICK);
    assign tick_live = is_tick && (i_line >= nmmc6_pkg::LINE_FIRST)
                       && (i_line <= nmmc6_pkg::LINE_LAST) && (i_render_bits == 2'b11);
    assign data_even = {i_data[7:1], 1'b0};

    // Next state from register writes and scanline ticks.
    always_comb begin
        n_bank_select = r_bank_select;
        n_prg         = r_prg;
        n_chr         = r_chr;
        n_mirror      = r_mirror;
        n_sram_en     = r_sram_en;
        n_sram_ctrl   = r_sram_ctrl;
        n_irq_latch   = r_irq_latch;
        n_irq_count   = r_irq_count;
        n_irq_en      = r_irq_en;
        n_irq_reload  = r_irq_reload;
        o_irq_pulse   = 1'b0;

        if (is_write) begin
            case (nmmc6_pkg::t_reg_sel'({i_addr[15:13], i_addr[0]}))
                nmmc6_pkg::REG_SELECT: begin
                    n_bank_select = i_data & nmmc6_pkg::SELECT_MASK;
                    n_sram_en     = i_data[nmmc6_pkg::SEL_SRAM_EN];
                end
                nmmc6_pkg::REG_BANK_DATA: begin
                    case (nmmc6_pkg::t_bank_tgt'(r_bank_select[2:0]))
                        nmmc6_pkg::TGT_CHR_PAIR0: begin
                            n_chr[0] = data_even;
                            n_chr[1] = {i_data[7:1], 1'b1};
                        end
                        nmmc6_pkg::TGT_CHR_PAIR1: begin
                            n_chr[2] = data_even;
                            n_chr[3] = {i_data[7:1], 1'b1};
                        end
                        nmmc6_pkg::TGT_CHR4: n_chr[4] = i_data;
                        nmmc6_pkg::TGT_CHR5: n_chr[5] = i_data;
                        nmmc6_pkg::TGT_CHR6: n_chr[6] = i_data;
                        nmmc6_pkg::TGT_CHR7: n_chr[7] = i_data;
                        nmmc6_pkg::TGT_PRG0: n_prg[0] = i_data[nmmc6_pkg::PRG_W-1:0];
                        default:             n_prg[1] = i_data[nmmc6_pkg::PRG_W-1:0];
                    endcase
                end
                nmmc6_pkg::REG_MIRROR:    n_mirror = i_data[0];
                nmmc6_pkg::REG_SRAM_CTRL: begin
                    if (r_sram_en) begin
                        n_sram_ctrl = i_data;
                    end
                end
                nmmc6_pkg::REG_IRQ_LATCH: n_irq_latch = i_data;
                nmmc6_pkg::REG_IRQ_RELD: begin
                    n_irq_count  = 8'd0;
                    n_irq_reload = 1'b1;
                end
                nmmc6_pkg::REG_IRQ_OFF:   n_irq_en = 1'b0;
                nmmc6_pkg::REG_IRQ_ON:    n_irq_en = 1'b1;
                default: ;
            endcase
        end

        // Counter reloads when empty or flagged, otherwise counts down.
        if (tick_live) begin
            if ((r_irq_count == 8'd0) || r_irq_reload) begin
                n_irq_count  = r_irq_latch;
                n_irq_reload = 1'b0;
            end else begin
                n_irq_count = r_irq_count - 8'd1;
            end
            o_irq_pulse = (n_irq_count == 8'd0) && r_irq_en;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select <= 8'd0;
            for (int i = 0; i < nmmc6_pkg::PRG_BANKS; i++) begin
                r_prg[i] <= nmmc6_pkg::PRG_W'(i);
            end
            for (int i = 0; i < nmmc6_pkg::CHR_BANKS; i++) begin
                r_chr[i] <= nmmc6_pkg::CHR_W'(i);
            end
            r_mirror      <= 1'b0;
            r_sram_en     <= 1'b0;
            r_sram_ctrl   <= 8'd0;
            r_irq_latch   <= 8'd0;
            r_irq_count   <= 8'd0;
            r_irq_en      <= 1'b0;
            r_irq_reload  <= 1'b0;
        end else begin
            r_bank_select <= n_bank_select;
            r_prg         <= n_prg;
            r_chr         <= n_chr;
            r_mirror      <= n_mirror;
            r_sram_en     <= n_sram_en;
            r_sram_ctrl   <= n_sram_ctrl;
            r_irq_latch   <= n_irq_latch;
            r_irq_count   <= n_irq_count;
            r_irq_en      <= n_irq_en;
            r_irq_reload  <= n_irq_reload;
        end
    end

    assign o_map.bank_select = r_bank_select;
    assign o_map.prg_banks   = r_prg;
    assign o_map.chr_banks   = r_chr;
    assign o_mirror          = n_mirror;
    assign o_sram_mapped     = n_sram_en;

    // A reload write leaves the counter empty with the reload flag set.
    a_reload_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_write && ({i_addr[15:13], i_addr[0]} == nmmc6_pkg::REG_IRQ_RELD)
        |=> r_irq_reload && (r_irq_count == 8'd0))
        else $error("IRQ reload write did not clear the counter");

    // The counter only moves on a live tick or a reload write.
    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick_live && !is_write |=> $stable(r_irq_count))
        else $error("IRQ counter changed without a tick or write");

    // An interrupt is only raised while enabled.
    a_pulse_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_irq_pulse |-> r_irq_en && tick_live)
        else $error("IRQ pulse without enable or live tick");

endmodule

// File: rtl/nmmc6_xlate.sv
// ----------------------------------------------------------------------------
// nmmc6_xlate: CPU and PPU address translation.
// Maps an 8 KB CPU slot to a PRG bank and a 1 KB PPU slot to a CHR bank
// using the current bank state, honoring the PRG swap and CHR inversion.
// ----------------------------------------------------------------------------
module nmmc6_xlate (
    input  logic [1:0]            i_mode,
    input  logic [15:0]           i_addr,
    input  nmmc6_pkg::t_map_state i_map,
    output logic [7:0]            o_bank,
    output logic                  o_bank_valid
);

    logic [1:0] prg_slot;
    logic [2:0] chr_slot;
    logic [7:0] prg_bank;

    // Swap mode exchanges the first and third CPU slots.
    assign prg_slot = {i_addr[14] ^ (~i_addr[13] & i_map.bank_select[nmmc6_pkg::SEL_PRG_SWAP]),
                       i_addr[13]};
    // Inversion mode exchanges the two 4 KB pattern halves.
    assign chr_slot = {i_addr[12] ^ i_map.bank_select[nmmc6_pkg::SEL_CHR_INV], i_addr[11:10]};

    always_comb begin
        case (prg_slot)
            2'd0:    prg_bank = {2'b00, i_map.prg_banks[0]};
            2'd1:    prg_bank = {2'b00, i_map.prg_banks[1]};
            2'd2:    prg_bank = nmmc6_pkg::PRG_FIXED_2ND;
            default: prg_bank = nmmc6_pkg::PRG_FIXED_LAST;
        endcase
    end

    // Select the bank for the translate modes; other modes report none.
    always_comb begin
        o_bank       = 8'd0;
        o_bank_valid = 1'b0;
        case (nmmc6_pkg::t_mode'(i_mode))
            nmmc6_pkg::MODE_CPU_XLATE: begin
                if (i_addr[15]) begin
                    o_bank       = prg_bank;
                    o_bank_valid = 1'b1;
                end
            end
            nmmc6_pkg::MODE_PPU_XLATE: begin
                if (i_addr[15:13] == 3'd0) begin
                    o_bank       = i_map.chr_banks[chr_slot];
                    o_bank_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/nes_mmc6_bank_mapper_top.sv
// ----------------------------------------------------------------------------
// nes_mmc6_bank_mapper_top: MMC6 cartridge bank mapper.
// Input register, register file with IRQ counter, address translator and
// result register.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction (i_valid/o_ready) carries one bus event selected by
// i_mode: a CPU register write, a scanline tick, a CPU address translate or
// a PPU address translate. Every transaction yields exactly one result
// transaction (o_valid/i_ready) with the bank, its valid flag, the IRQ pulse
// and the current mirroring and work RAM flags.
// An accepted event is held in the input register, then it is decoded against
// the mapper state and the result is captured in the output register while
// the state updates.
// Throughput is one transaction per cycle while i_ready stays high; the
// decode and table lookup between the two registers are combinational.
// The input register accepts a new transaction whenever it is empty or its
// contents move on, so a waiting result does not block intake until both
// registers are full. When the receiver holds i_ready low, the result holds
// and o_ready drops once the input register is also occupied.
// Synchronous active-low reset empties both registers and returns all banks
// to their power-up mapping with IRQs disabled.
// ----------------------------------------------------------------------------
module nes_mmc6_bank_mapper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_data,
    input  logic [8:0]  i_line,
    input  logic [1:0]  i_render_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_bank,
    output logic        o_bank_valid,
    output logic        o_irq_pulse,
    output logic        o_mirror_horizontal,
    output logic        o_sram_mapped
);

    logic        r_in_valid;
    logic [1:0]  r_in_mode;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_data;
    logic [8:0]  r_in_line;
    logic [1:0]  r_in_render;

    logic        r_out_valid;
    logic [7:0]  r_out_bank;
    logic        r_out_bank_valid;
    logic        r_out_irq;
    logic        r_out_mirror;
    logic        r_out_sram;

    logic        advance;
    logic        process;
    logic        in_take;

    nmmc6_pkg::t_map_state map;
    logic        irq_pulse;
    logic        mirror;
    logic        sram_mapped;
    logic [7:0]  bank;
    logic        bank_valid;

    // Pipeline control.
    assign advance = !r_out_valid || i_ready;
    assign process = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode   <= i_mode;
            r_in_addr   <= i_addr;
            r_in_data   <= i_data;
            r_in_line   <= i_line;
            r_in_render <= i_render_bits;
        end
    end

    nmmc6_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (process),
        .i_mode        (r_in_mode),
        .i_addr        (r_in_addr),
        .i_data        (r_in_data),
        .i_line        (r_in_line),
        .i_render_bits (r_in_render),
        .o_map         (map),
        .o_irq_pulse   (irq_pulse),
        .o_mirror      (mirror),
        .o_sram_mapped (sram_mapped)
    );

    nmmc6_xlate u_xlate (
        .i_mode       (r_in_mode),
        .i_addr       (r_in_addr),
        .i_map        (map),
        .o_bank       (bank),
        .o_bank_valid (bank_valid)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_bank       <= bank;
            r_out_bank_valid <= bank_valid;
            r_out_irq        <= irq_pulse;
            r_out_mirror     <= mirror;
            r_out_sram       <= sram_mapped;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_bank              = r_out_bank;
    assign o_bank_valid        = r_out_bank_valid;
    assign o_irq_pulse         = r_out_irq;
    assign o_mirror_horizontal = r_out_mirror;
    assign o_sram_mapped       = r_out_sram;

    // A processed event always lands in the result register.
    a_process_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> r_out_valid)
        else $error("Processed transaction did not reach the result register");

    // A bank is reported only for a translate, never alongside an IRQ.
    a_bank_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_irq |-> !r_out_bank_valid && (r_out_bank == 8'd0))
        else $error("IRQ pulse reported together with a bank");

    // Without a valid window the bank reads zero.
    a_bank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_bank_valid |-> r_out_bank == 8'd0)
        else $error("Nonzero bank outside a banked window");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("Pipeline not empty after reset");

endmodule

// File: bench/tb_nes_mmc6_bank_mapper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nes_mmc6_bank_mapper_top: self-checking bench for the MMC6 bank mapper.
// A queue of bus events (register writes, scanline ticks, CPU and PPU
// translates) feeds a clocked driver. Each accepted transaction runs through
// a local model of the mapper. A clocked monitor compares every result
// transaction with the oldest predicted result. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_nes_mmc6_bank_mapper_top;

    // One bus event, as driven on the input channel.
    typedef struct {
        nmmc6_pkg::t_mode mode;
        logic [15:0]      addr;
        logic [7:0]       data;
        logic [8:0]       line;
        logic [1:0]       render_bits;
    } t_bus_event;

    // One mapper answer, as seen on the output channel.
    typedef struct {
        logic [7:0] bank;
        logic       bank_valid;
        logic       irq_pulse;
        logic       mirror_horizontal;
        logic       sram_mapped;
    } t_map_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = nmmc6_pkg::MODE_WRITE;
    logic [15:0] i_addr = '0;
    logic [7:0]  i_data = '0;
    logic [8:0]  i_line = '0;
    logic [1:0]  i_render_bits = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_bank;
    logic        o_bank_valid;
    logic        o_irq_pulse;
    logic        o_mirror_horizontal;
    logic        o_sram_mapped;

    t_bus_event  bus_events[$];
    t_map_answer answers_due[$];
    int          error_count = 0;

    // Mapper state mirrored by the bench.
    logic [7:0] m_select;
    logic [5:0] m_prg[nmmc6_pkg::PRG_BANKS];
    logic [7:0] m_chr[nmmc6_pkg::CHR_BANKS];
    logic       m_mirror;
    logic       m_sram_en;
    logic [7:0] m_sram_ctrl;
    logic [7:0] m_irq_latch;
    logic [7:0] m_irq_count;
    logic       m_irq_en;
    logic       m_irq_reload;

    int send_gap = 0;
    int send_quiet = 0;
    int recv_stall = 0;
    int recv_quiet = 0;

    nes_mmc6_bank_mapper_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_mode              (i_mode),
        .i_addr              (i_addr),
        .i_data              (i_data),
        .i_line              (i_line),
        .i_render_bits       (i_render_bits),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_bank              (o_bank),
        .o_bank_valid        (o_bank_valid),
        .o_irq_pulse         (o_irq_pulse),
        .o_mirror_horizontal (o_mirror_horizontal),
        .o_sram_mapped       (o_sram_mapped)
    );

    always #2 i_clk = ~i_clk;

    // Power-up mapping of the mirrored state.
    task automatic map_power_up();
        m_select     = '0;
        m_prg[0]     = 6'd0;
        m_prg[1]     = 6'd1;
        for (int i = 0; i < nmmc6_pkg::CHR_BANKS; i++) begin
            m_chr[i] = 8'(i);
        end
        m_mirror     = 1'b0;
        m_sram_en    = 1'b0;
        m_sram_ctrl  = '0;
        m_irq_latch  = '0;
        m_irq_count  = '0;
        m_irq_en     = 1'b0;
        m_irq_reload = 1'b0;
    endtask

    // Apply one bus event to the mirrored state and form its answer.
    task automatic map_event(input t_bus_event ev, output t_map_answer ans);
        logic [1:0] prg_slot;
        logic [2:0] chr_slot;
        ans = '{default: '0};
        case (ev.mode)
            nmmc6_pkg::MODE_WRITE: begin
                // Addresses below 0x8000 match no register and are dropped.
                if (ev.addr[15]) begin
                    case (nmmc6_pkg::t_reg_sel'({ev.addr[15:13], ev.addr[0]}))
                        nmmc6_pkg::REG_SELECT: begin
                            m_select  = ev.data & nmmc6_pkg::SELECT_MASK;
                            m_sram_en = ev.data[nmmc6_pkg::SEL_SRAM_EN];
                        end
                        nmmc6_pkg::REG_BANK_DATA: begin
                            case (nmmc6_pkg::t_bank_tgt'(m_select[2:0]))
                                nmmc6_pkg::TGT_CHR_PAIR0: begin
                                    m_chr[0] = {ev.data[7:1], 1'b0};
                                    m_chr[1] = {ev.data[7:1], 1'b1};
                                end
                                nmmc6_pkg::TGT_CHR_PAIR1: begin
                                    m_chr[2] = {ev.data[7:1], 1'b0};
                                    m_chr[3] = {ev.data[7:1], 1'b1};
                                end
                                nmmc6_pkg::TGT_CHR4: m_chr[4] = ev.data;
                                nmmc6_pkg::TGT_CHR5: m_chr[5] = ev.data;
                                nmmc6_pkg::TGT_CHR6: m_chr[6] = ev.data;
                                nmmc6_pkg::TGT_CHR7: m_chr[7] = ev.data;
                                nmmc6_pkg::TGT_PRG0: m_prg[0] = ev.data[5:0];
                                default:             m_prg[1] = ev.data[5:0];
                            endcase
                        end
                        nmmc6_pkg::REG_MIRROR: m_mirror = ev.data[0];
                        nmmc6_pkg::REG_SRAM_CTRL: begin
                            if (m_sram_en) begin
                                m_sram_ctrl = ev.data;
                            end
                        end
                        nmmc6_pkg::REG_IRQ_LATCH: m_irq_latch = ev.data;
                        nmmc6_pkg::REG_IRQ_RELD: begin
                            m_irq_count  = '0;
                            m_irq_reload = 1'b1;
                        end
                        nmmc6_pkg::REG_IRQ_OFF: m_irq_en = 1'b0;
                        default:                m_irq_en = 1'b1;
                    endcase
                end
            end
            nmmc6_pkg::MODE_TICK: begin
                // Counts only inside the visible window with both render bits on.
                if (ev.line >= nmmc6_pkg::LINE_FIRST && ev.line <= nmmc6_pkg::LINE_LAST
                        && ev.render_bits == 2'b11) begin
                    if (m_irq_count == 0 || m_irq_reload) begin
                        m_irq_reload = 1'b0;
                        m_irq_count  = m_irq_latch;
                    end else begin
                        m_irq_count = m_irq_count - 8'd1;
                    end
                    ans.irq_pulse = (m_irq_count == 0) && m_irq_en;
                end
            end
            nmmc6_pkg::MODE_CPU_XLATE: begin
                if (ev.addr[15]) begin
                    prg_slot = ev.addr[14:13];
                    if (!prg_slot[0] && m_select[nmmc6_pkg::SEL_PRG_SWAP]) begin
                        prg_slot[1] = ~prg_slot[1];
                    end
                    case (prg_slot)
                        2'd0:    ans.bank = {2'b00, m_prg[0]};
                        2'd1:    ans.bank = {2'b00, m_prg[1]};
                        2'd2:    ans.bank = nmmc6_pkg::PRG_FIXED_2ND;
                        default: ans.bank = nmmc6_pkg::PRG_FIXED_LAST;
                    endcase
                    ans.bank_valid = 1'b1;
                end
            end
            default: begin
                if (ev.addr < 16'h2000) begin
                    chr_slot = ev.addr[12:10];
                    if (m_select[nmmc6_pkg::SEL_CHR_INV]) begin
                        chr_slot[2] = ~chr_slot[2];
                    end
                    ans.bank       = m_chr[chr_slot];
                    ans.bank_valid = 1'b1;
                end
            end
        endcase
        ans.mirror_horizontal = m_mirror;
        ans.sram_mapped       = m_sram_en;
    endtask

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic queue_event(input nmmc6_pkg::t_mode mode, input logic [15:0] addr,
                               input logic [7:0] data, input logic [8:0] line,
                               input logic [1:0] render_bits);
        bus_events.push_back('{mode, addr, data, line, render_bits});
    endtask

    // Register address with random don't-care bits between the decoded ones.
    function automatic logic [15:0] reg_addr(input nmmc6_pkg::t_reg_sel sel);
        logic [11:0] filler;
        filler = 12'($urandom);
        return {sel[3:1], filler, sel[0]};
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 2);
        end else if (r < 92) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(12, 40);
    endfunction

    // Driver: predicts each accepted transaction, then presents the next one.
    always @(posedge i_clk) begin : driver
        t_bus_event  ev;
        t_map_answer ans;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                map_event('{nmmc6_pkg::t_mode'(i_mode), i_addr, i_data, i_line,
                            i_render_bits}, ans);
                answers_due.push_back(ans);
            end
            if (i_valid && !o_ready) begin
                // Hold the transaction until it is taken.
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (bus_events.size() > 0) begin
                ev = bus_events.pop_front();
                i_mode        <= ev.mode;
                i_addr        <= ev.addr;
                i_data        <= ev.data;
                i_line        <= ev.line;
                i_render_bits <= ev.render_bits;
                i_valid       <= 1'b1;
                if (send_quiet > 0) begin
                    send_quiet--;
                end else if ($urandom_range(0, 99) == 0) begin
                    send_quiet = $urandom_range(30, 80);
                end else if ($urandom_range(0, 1) == 0) begin
                    send_gap = idle_len();
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction and stalls the receiver at random.
    always @(posedge i_clk) begin : monitor
        t_map_answer want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (answers_due.size() == 0) begin
                    report_error("result transaction with no prediction pending");
                end else begin
                    want = answers_due.pop_front();
                    check_field("bank", o_bank, want.bank);
                    check_field("bank_valid", o_bank_valid, want.bank_valid);
                    check_field("irq_pulse", o_irq_pulse, want.irq_pulse);
                    check_field("mirror_horizontal", o_mirror_horizontal,
                                want.mirror_horizontal);
                    check_field("sram_mapped", o_sram_mapped, want.sram_mapped);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (recv_quiet > 0) begin
                    recv_quiet--;
                end else if ($urandom_range(0, 99) == 0) begin
                    recv_quiet = $urandom_range(30, 80);
                end else if ($urandom_range(0, 5) == 0) begin
                    recv_stall = idle_len();
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int r;
        nmmc6_pkg::t_reg_sel sel;
        map_power_up();

        // Power-up mapping, both banked windows and the addresses outside them.
        queue_event(nmmc6_pkg::MODE_CPU_XLATE, 16'h8000, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_CPU_XLATE, 16'hA000, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_CPU_XLATE, 16'hDFFF, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_CPU_XLATE, 16'hFFFF, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_CPU_XLATE, 16'h7FFF, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_PPU_XLATE, 16'h0000, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_PPU_XLATE, 16'h1FFF, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_PPU_XLATE, 16'h2000, 8'h00, 9'd0, 2'b00);
        // Select with every bit set: last PRG target, swap, inversion, work RAM.
        queue_event(nmmc6_pkg::MODE_WRITE, 16'h8000, 8'hFF, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_WRITE, 16'h8001, 8'hFF, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_WRITE, 16'hA000, 8'h01, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_WRITE, 16'hA001, 8'hAA, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_WRITE, 16'hC000, 8'h02, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_WRITE, 16'hC001, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_WRITE, 16'hE001, 8'h00, 9'd0, 2'b00);
        // Ticks just outside and inside the counted lines, one with a render bit off.
        queue_event(nmmc6_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd19, 2'b11);
        queue_event(nmmc6_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd20, 2'b11);
        queue_event(nmmc6_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd100, 2'b01);
        queue_event(nmmc6_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd260, 2'b11);
        queue_event(nmmc6_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd261, 2'b11);
        queue_event(nmmc6_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd511, 2'b11);
        queue_event(nmmc6_pkg::MODE_TICK, 16'h0000, 8'h00, 9'd200, 2'b11);
        // A write below the register window is dropped.
        queue_event(nmmc6_pkg::MODE_WRITE, 16'h7FFF, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_CPU_XLATE, 16'hC000, 8'h00, 9'd0, 2'b00);
        queue_event(nmmc6_pkg::MODE_PPU_XLATE, 16'h0400, 8'h00, 9'd0, 2'b00);

        // Random part: mostly well-formed register sequences, ticks and lookups.
        while (bus_events.size() < 1475) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                // Bank switch: select a target, then write its bank.
                queue_event(nmmc6_pkg::MODE_WRITE, reg_addr(nmmc6_pkg::REG_SELECT),
                            8'($urandom), 9'($urandom), 2'($urandom));
                queue_event(nmmc6_pkg::MODE_WRITE, reg_addr(nmmc6_pkg::REG_BANK_DATA),
                            8'($urandom), 9'($urandom), 2'($urandom));
            end else if (r < 35) begin
                sel = nmmc6_pkg::t_reg_sel'({1'b1, 3'($urandom_range(2, 7))});
                // Small latch values make the counter reach zero often.
                queue_event(nmmc6_pkg::MODE_WRITE, reg_addr(sel),
                            (sel == nmmc6_pkg::REG_IRQ_LATCH && $urandom_range(0, 1))
                                ? 8'($urandom_range(0, 8)) : 8'($urandom),
                            9'($urandom), 2'($urandom));
            end else if (r < 40) begin
                queue_event(nmmc6_pkg::MODE_WRITE, 16'($urandom), 8'($urandom),
                            9'($urandom), 2'($urandom));
            end else if (r < 65) begin
                if ($urandom_range(0, 4) != 0) begin
                    queue_event(nmmc6_pkg::MODE_TICK, 16'($urandom), 8'($urandom),
                                9'($urandom_range(nmmc6_pkg::LINE_FIRST,
                                                  nmmc6_pkg::LINE_LAST)),
                                2'b11);
                end else begin
                    queue_event(nmmc6_pkg::MODE_TICK, 16'($urandom), 8'($urandom),
                                9'($urandom), 2'($urandom));
                end
            end else if (r < 83) begin
                queue_event(nmmc6_pkg::MODE_CPU_XLATE,
                            $urandom_range(0, 4) != 0 ? {1'b1, 15'($urandom)}
                                                      : 16'($urandom),
                            8'($urandom), 9'($urandom), 2'($urandom));
            end else begin
                queue_event(nmmc6_pkg::MODE_PPU_XLATE,
                            $urandom_range(0, 4) != 0 ? {3'b000, 13'($urandom)}
                                                      : 16'($urandom),
                            8'($urandom), 9'($urandom), 2'($urandom));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every transaction is sent and answered, then let the pipe drain.
        do begin
            @(negedge i_clk);
        end while (bus_events.size() != 0 || i_valid || answers_due.size() != 0);
        repeat (8) @(negedge i_clk);
        if (answers_due.size() != 0) begin
            report_error($sformatf("%0d predicted results never arrived",
                                   answers_due.size()));
        end
        if (error_count == 0) begin
            $display("tb_nes_mmc6_bank_mapper_top: clean");
        end else begin
            $display("tb_nes_mmc6_bank_mapper_top: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4_000_000;
        $display("tb_nes_mmc6_bank_mapper_top: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/nmmc6_pkg.sv
rtl/nmmc6_regs.sv
rtl/nmmc6_xlate.sv
rtl/nes_mmc6_bank_mapper_top.sv
bench/tb_nes_mmc6_bank_mapper_top.sv
